// ===== hw/rtl/cdo_pkg.sv =====
// Shared widths, constants, register codes and the CORDIC arctangent table.
`default_nettype none

package cdo_pkg;

  // Default CORDIC iteration count and table size
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 24;
  localparam int IDX_W            = 5;

  // Port field widths
  localparam int SPEED_W = 16;
  localparam int WR_W    = 16;
  localparam int INV_W   = 20;
  localparam int MAXH_W  = 19;
  localparam int ANG_W   = 19;
  localparam int HGT_W   = 20;
  localparam int HSUM_W  = HGT_W + 1;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Shared multiplier: signed A x signed B, registered product
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Internal datapath widths
  localparam int DIST_W = 20;  // travel distances and rounded products, Q16
  localparam int DIFF_W = 21;  // wheel difference and sum
  localparam int WRAP_W = 24;  // angle accumulator before wrapping
  localparam int TRIG_W = 32;  // CORDIC vector and angle, Q30

  // Angle constants in Q16
  localparam logic signed [WRAP_W-1:0] PI_Q16         = 24'sd205887;
  localparam logic signed [WRAP_W-1:0] NEG_PI_Q16     = -24'sd205887;
  localparam logic signed [WRAP_W-1:0] TWO_PI_Q16     = 24'sd411775;
  localparam logic signed [ANG_W-1:0]  ANG_PI         = 19'sd205887;
  localparam logic signed [ANG_W-1:0]  ANG_NEG_PI     = -19'sd205887;
  localparam logic signed [ANG_W-1:0]  ANG_HALF_PI    = 19'sd102944;
  localparam logic signed [ANG_W-1:0]  ANG_NEG_HALF_PI = -19'sd102944;

  // pi/180 in Q0.32 and the CORDIC start vector length in Q30
  localparam logic signed [MUL_B_W-1:0] DEG2RAD_Q32     = 28'sd74961321;
  localparam logic signed [TRIG_W-1:0]  CORDIC_GAIN_Q30 = 32'sd652032874;

  // Round-half-up offsets for the product shifts
  localparam logic signed [PROD_W-1:0] RND40 = PROD_W'(64'd1 << 39);
  localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(64'd1 << 29);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(64'd1 << 15);

  // Register reset values
  localparam logic [WR_W-1:0]   WR_RESET     = 16'd6554;
  localparam logic [INV_W-1:0]  INV_WB_RESET = 20'd65536;
  localparam logic [INV_W-1:0]  INV_CR_RESET = 20'd65536;
  localparam logic [MAXH_W-1:0] MAXH_RESET   = 19'd65536;

  // Register index codes (byte address / 4)
  typedef enum logic [1:0] {
    REG_WHEEL_RADIUS   = 2'd0,
    REG_INV_WHEELBASE  = 2'd1,
    REG_INV_CYL_RADIUS = 2'd2,
    REG_MAX_HEIGHT     = 2'd3
  } reg_idx_t;

  // CORDIC result
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  // atan(2^-i) in Q30
  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    logic signed [TRIG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sd843314857;
      5'd1:    v = 32'sd497837829;
      5'd2:    v = 32'sd263043837;
      5'd3:    v = 32'sd133525159;
      5'd4:    v = 32'sd67021687;
      5'd5:    v = 32'sd33543516;
      5'd6:    v = 32'sd16775851;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194283;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048576;
      5'd11:   v = 32'sd524288;
      5'd12:   v = 32'sd262144;
      5'd13:   v = 32'sd131072;
      5'd14:   v = 32'sd65536;
      5'd15:   v = 32'sd32768;
      5'd16:   v = 32'sd16384;
      5'd17:   v = 32'sd8192;
      5'd18:   v = 32'sd4096;
      5'd19:   v = 32'sd2048;
      5'd20:   v = 32'sd1024;
      5'd21:   v = 32'sd512;
      5'd22:   v = 32'sd256;
      5'd23:   v = 32'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdo_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module cdo_mul (
  input  logic                                clk,
  input  logic signed [cdo_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [cdo_pkg::MUL_B_W-1:0] b_i,
  output logic signed [cdo_pkg::PROD_W-1:0]  p_o
);

  logic signed [cdo_pkg::PROD_W-1:0] p_r;

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= cdo_pkg::PROD_W'(a_i) * cdo_pkg::PROD_W'(b_i);
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cdo_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on a shared shift/add unit.
`default_nettype none

module cdo_cordic #(
  parameter int CORDIC_STEPS = cdo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic signed [cdo_pkg::ANG_W-1:0]   angle_i,
  output logic                               done_o,
  output cdo_pkg::trig_t                     trig_o
);

  localparam int STEPS = (CORDIC_STEPS > cdo_pkg::ATAN_COUNT) ?
                         cdo_pkg::ATAN_COUNT : CORDIC_STEPS;
  localparam logic [cdo_pkg::IDX_W-1:0] LAST_IDX = cdo_pkg::IDX_W'(STEPS - 1);

  logic                               busy_r;
  logic                               done_r;
  logic                               neg_r;
  logic [cdo_pkg::IDX_W-1:0]          idx_r;
  logic signed [cdo_pkg::TRIG_W-1:0]  x_r, y_r, z_r;

  logic signed [cdo_pkg::ANG_W-1:0]   fold_ang;
  logic                               fold_neg;
  logic signed [cdo_pkg::TRIG_W-1:0]  z_start;
  logic signed [cdo_pkg::TRIG_W-1:0]  x_sh, y_sh, at;
  logic signed [cdo_pkg::TRIG_W-1:0]  x_nxt, y_nxt, z_nxt;

  // Fold the angle into [-pi/2, pi/2]; results are negated for the folded half
  always_comb begin
    fold_ang = angle_i;
    fold_neg = 1'b0;
    if (angle_i > cdo_pkg::ANG_HALF_PI) begin
      fold_ang = angle_i - cdo_pkg::ANG_PI;
      fold_neg = 1'b1;
    end else if (angle_i < cdo_pkg::ANG_NEG_HALF_PI) begin
      fold_ang = angle_i + cdo_pkg::ANG_PI;
      fold_neg = 1'b1;
    end
  end

  // Q16 -> Q30
  assign z_start = cdo_pkg::TRIG_W'(fold_ang) <<< 14;

  // One micro-rotation
  assign x_sh = x_r >>> idx_r;
  assign y_sh = y_r >>> idx_r;
  assign at   = cdo_pkg::atan_q30(idx_r);

  always_comb begin
    if (!z_r[cdo_pkg::TRIG_W-1]) begin
      x_nxt = x_r - y_sh;
      y_nxt = y_r + x_sh;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + y_sh;
      y_nxt = y_r - x_sh;
      z_nxt = z_r + at;
    end
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= cdo_pkg::IDX_W'(idx_r + 1'b1);
        if (idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Vector and residual angle
  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r   <= cdo_pkg::CORDIC_GAIN_Q30;
      y_r   <= '0;
      z_r   <= z_start;
      neg_r <= fold_neg;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done_o       = done_r;
  assign trig_o.cos_v = neg_r ? -x_r : x_r;
  assign trig_o.sin_v = neg_r ? -y_r : y_r;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("cordic started while busy");

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start_i && idx_r != LAST_IDX) |=>
      (busy_r && idx_r == cdo_pkg::IDX_W'($past(idx_r) + 1'b1)))
    else $error("cordic step counter skipped");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("cordic done without a finished run");

endmodule

`default_nettype wire

// ===== hw/rtl/cylinder_diff_drive_odometry_top.sv =====
// Top level: wheel-odometry pose on a cylinder wall, sequencer around a shared multiplier and CORDIC.
//
//   channel   signals                                        request moves
//   in        in_valid/in_ready, in_left_speed/right_speed   one frame tick of wheel rotation
//   out       out_valid/out_ready, out_azimuth/wall_height/  pose after the tick
//             out_heading
//   config    psel/penable/pwrite/paddr/pwdata/prdata/pready register write or read
//
// The time one request takes is set by the CORDIC iterations on the shared shift/add unit and the
// eight passes through the one multiplier, and it grows for each extra multiple of 2*pi removed
// from heading or azimuth; in_ready is high again once the sequencer is back in idle.
// A finished pose waits in the output register while the next request is accepted; the
// sequencer stalls only when it would overwrite a pose not yet taken.
// rst_n (synchronous) clears the pose to zero and loads the register defaults.
`default_nettype none

module cylinder_diff_drive_odometry_top #(
  parameter int CORDIC_STEPS = cdo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cdo_pkg::SPEED_W-1:0]   in_left_speed,
  input  logic signed [cdo_pkg::SPEED_W-1:0]   in_right_speed,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cdo_pkg::ANG_W-1:0]     out_azimuth,
  output logic signed [cdo_pkg::HGT_W-1:0]     out_wall_height,
  output logic signed [cdo_pkg::ANG_W-1:0]     out_heading,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cdo_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [cdo_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [cdo_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LW,      // left speed * wheel radius
    S_LK,      // * deg-to-rad
    S_RW,      // right speed * wheel radius, left distance out
    S_RK,      // * deg-to-rad
    S_DR,      // right distance, mean and difference
    S_TURN,    // difference * inverse wheelbase
    S_HEAD,    // heading + turn
    S_WRAP_H,  // wrap heading, start CORDIC
    S_TRIG,    // wait for CORDIC, then mean * cos
    S_MS,      // mean * sin
    S_MI,      // rounded cos part * inverse cylinder radius
    S_AZ,      // azimuth + change, height update
    S_WRAP_A   // wrap azimuth, load result
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [cdo_pkg::WR_W-1:0]   wheel_radius_r;
  logic [cdo_pkg::INV_W-1:0]  inv_wheelbase_r;
  logic [cdo_pkg::INV_W-1:0]  inv_cyl_radius_r;
  logic [cdo_pkg::MAXH_W-1:0] max_height_r;

  // Pose
  logic signed [cdo_pkg::ANG_W-1:0] azimuth_r;
  logic signed [cdo_pkg::HGT_W-1:0] height_r;
  logic signed [cdo_pkg::ANG_W-1:0] heading_r;

  // Working registers
  logic signed [cdo_pkg::SPEED_W-1:0] ls_r, rs_r;
  logic signed [cdo_pkg::DIST_W-1:0]  dl_r, mean_r, tc_r, dh_r;
  logic signed [cdo_pkg::DIFF_W-1:0]  diff_r;
  logic signed [cdo_pkg::WRAP_W-1:0]  w_r;

  // Output registers
  logic                              out_valid_r;
  logic signed [cdo_pkg::ANG_W-1:0]  out_azimuth_r;
  logic signed [cdo_pkg::HGT_W-1:0]  out_wall_height_r;
  logic signed [cdo_pkg::ANG_W-1:0]  out_heading_r;

  // Shared units
  logic signed [cdo_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cdo_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cdo_pkg::PROD_W-1:0]  prod;
  logic                               trig_start;
  logic                               trig_done;
  cdo_pkg::trig_t                     trig;

  cdo_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  cdo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (trig_start),
    .angle_i (cdo_pkg::ANG_W'(w_r)),
    .done_o  (trig_done),
    .trig_o  (trig)
  );

  // Rounded product shifts (round half up)
  logic signed [cdo_pkg::PROD_W-1:0] r40_full, r30_full, r16_full;
  logic signed [cdo_pkg::DIST_W-1:0] dist_now, r30_now;
  logic signed [cdo_pkg::WRAP_W-1:0] r16_now;

  assign r40_full = (prod + cdo_pkg::RND40) >>> 40;
  assign r30_full = (prod + cdo_pkg::RND30) >>> 30;
  assign r16_full = (prod + cdo_pkg::RND16) >>> 16;
  assign dist_now = cdo_pkg::DIST_W'(r40_full);
  assign r30_now  = cdo_pkg::DIST_W'(r30_full);
  assign r16_now  = cdo_pkg::WRAP_W'(r16_full);

  // Mean travel and wheel difference
  logic signed [cdo_pkg::DIFF_W-1:0] sum_lr, diff_lr;
  assign sum_lr  = cdo_pkg::DIFF_W'(dl_r) + cdo_pkg::DIFF_W'(dist_now) + cdo_pkg::DIFF_W'(1);
  assign diff_lr = cdo_pkg::DIFF_W'(dist_now) - cdo_pkg::DIFF_W'(dl_r);

  // Angle wrap test
  logic w_hi, w_lo, w_ok;
  assign w_hi = w_r > cdo_pkg::PI_Q16;
  assign w_lo = w_r < cdo_pkg::NEG_PI_Q16;
  assign w_ok = !w_hi && !w_lo;

  // Height step with clamp
  logic signed [cdo_pkg::HSUM_W-1:0] h_sum, h_lim, h_clamp;
  assign h_sum = cdo_pkg::HSUM_W'(height_r) + cdo_pkg::HSUM_W'(dh_r);
  assign h_lim = cdo_pkg::HSUM_W'(max_height_r);

  always_comb begin
    h_clamp = h_sum;
    if (h_sum > h_lim) begin
      h_clamp = h_lim;
    end
    if (h_clamp < -h_lim) begin
      h_clamp = -h_lim;
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LW: begin
        mul_a = cdo_pkg::MUL_A_W'(ls_r);
        mul_b = cdo_pkg::MUL_B_W'(wheel_radius_r);
      end
      S_LK, S_RK: begin
        mul_a = prod[cdo_pkg::MUL_A_W-1:0];
        mul_b = cdo_pkg::DEG2RAD_Q32;
      end
      S_RW: begin
        mul_a = cdo_pkg::MUL_A_W'(rs_r);
        mul_b = cdo_pkg::MUL_B_W'(wheel_radius_r);
      end
      S_TURN: begin
        mul_a = cdo_pkg::MUL_A_W'(diff_r);
        mul_b = cdo_pkg::MUL_B_W'(inv_wheelbase_r);
      end
      S_TRIG: begin
        mul_a = trig.cos_v;
        mul_b = cdo_pkg::MUL_B_W'(mean_r);
      end
      S_MS: begin
        mul_a = trig.sin_v;
        mul_b = cdo_pkg::MUL_B_W'(mean_r);
      end
      S_MI: begin
        mul_a = cdo_pkg::MUL_A_W'(tc_r);
        mul_b = cdo_pkg::MUL_B_W'(inv_cyl_radius_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign trig_start = (state_r == S_WRAP_H) && w_ok;

  // Sequencer, pose and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      azimuth_r   <= '0;
      height_r    <= '0;
      heading_r   <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_LW;
          end
        end
        S_LW:   state_r <= S_LK;
        S_LK:   state_r <= S_RW;
        S_RW:   state_r <= S_RK;
        S_RK:   state_r <= S_DR;
        S_DR:   state_r <= S_TURN;
        S_TURN: state_r <= S_HEAD;
        S_HEAD: state_r <= S_WRAP_H;
        S_WRAP_H: begin
          if (w_ok) begin
            heading_r <= cdo_pkg::ANG_W'(w_r);
            state_r   <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (trig_done) begin
            state_r <= S_MS;
          end
        end
        S_MS:   state_r <= S_MI;
        S_MI:   state_r <= S_AZ;
        S_AZ: begin
          height_r <= cdo_pkg::HGT_W'(h_clamp);
          state_r  <= S_WRAP_A;
        end
        S_WRAP_A: begin
          if (w_ok && (!out_valid_r || out_ready)) begin
            azimuth_r         <= cdo_pkg::ANG_W'(w_r);
            out_azimuth_r     <= cdo_pkg::ANG_W'(w_r);
            out_wall_height_r <= height_r;
            out_heading_r     <= heading_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ls_r <= in_left_speed;
          rs_r <= in_right_speed;
        end
      end
      S_RW: dl_r <= dist_now;
      S_DR: begin
        mean_r <= cdo_pkg::DIST_W'(sum_lr >>> 1);
        diff_r <= diff_lr;
      end
      S_HEAD: w_r <= cdo_pkg::WRAP_W'(heading_r) + r16_now;
      S_WRAP_H, S_WRAP_A: begin
        if (w_hi) begin
          w_r <= w_r - cdo_pkg::TWO_PI_Q16;
        end else if (w_lo) begin
          w_r <= w_r + cdo_pkg::TWO_PI_Q16;
        end
      end
      S_MS: tc_r <= r30_now;
      S_MI: dh_r <= r30_now;
      S_AZ: w_r  <= cdo_pkg::WRAP_W'(azimuth_r) + r16_now;
      default: begin
      end
    endcase
  end

  // Configuration writes
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r   <= cdo_pkg::WR_RESET;
      inv_wheelbase_r  <= cdo_pkg::INV_WB_RESET;
      inv_cyl_radius_r <= cdo_pkg::INV_CR_RESET;
      max_height_r     <= cdo_pkg::MAXH_RESET;
    end else if (cfg_wr) begin
      unique case (cdo_pkg::reg_idx_t'(paddr[3:2]))
        cdo_pkg::REG_WHEEL_RADIUS:   wheel_radius_r   <= pwdata[cdo_pkg::WR_W-1:0];
        cdo_pkg::REG_INV_WHEELBASE:  inv_wheelbase_r  <= pwdata[cdo_pkg::INV_W-1:0];
        cdo_pkg::REG_INV_CYL_RADIUS: inv_cyl_radius_r <= pwdata[cdo_pkg::INV_W-1:0];
        cdo_pkg::REG_MAX_HEIGHT:     max_height_r     <= pwdata[cdo_pkg::MAXH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    unique case (cdo_pkg::reg_idx_t'(paddr[3:2]))
      cdo_pkg::REG_WHEEL_RADIUS:   prdata = cdo_pkg::APB_DATA_W'(wheel_radius_r);
      cdo_pkg::REG_INV_WHEELBASE:  prdata = cdo_pkg::APB_DATA_W'(inv_wheelbase_r);
      cdo_pkg::REG_INV_CYL_RADIUS: prdata = cdo_pkg::APB_DATA_W'(inv_cyl_radius_r);
      cdo_pkg::REG_MAX_HEIGHT:     prdata = cdo_pkg::APB_DATA_W'(max_height_r);
      default:                     prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_azimuth     = out_azimuth_r;
  assign out_wall_height = out_wall_height_r;
  assign out_heading     = out_heading_r;

  // Checks
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r <= cdo_pkg::ANG_PI) && (heading_r >= cdo_pkg::ANG_NEG_PI))
    else $error("heading outside [-pi, pi]");

  a_azimuth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (azimuth_r <= cdo_pkg::ANG_PI) && (azimuth_r >= cdo_pkg::ANG_NEG_PI))
    else $error("azimuth outside [-pi, pi]");

  a_trig_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    trig_done |-> (state_r == S_TRIG))
    else $error("cordic result arrived outside the wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LW && !in_ready))
    else $error("accepted request did not start the sequence");

endmodule

`default_nettype wire
